FILE: hw/rtl/tpbuf_pkg.sv
package tpbuf_pkg;

    localparam int ID_SPACE      = 32;
    localparam int ID_W          = 5;
    localparam int SIZE_W        = 16;
    localparam int COUNT_W       = 8;
    localparam int SMALL_BUFFERS = 16;
    localparam int LARGE_BUFFERS = 16;

    localparam int SMALL_EFF = (SMALL_BUFFERS < ID_SPACE) ? SMALL_BUFFERS : ID_SPACE;
    localparam int LARGE_EFF = (LARGE_BUFFERS < (ID_SPACE - SMALL_EFF)) ?
                               LARGE_BUFFERS : (ID_SPACE - SMALL_EFF);
    localparam int TOTAL_EFF = SMALL_EFF + LARGE_EFF;

    localparam logic [COUNT_W-1:0] COUNT_MAX         = 8'd255;
    localparam logic [COUNT_W-1:0] COUNT_ONE         = 8'd1;
    localparam logic [SIZE_W-1:0]  SMALL_LIMIT_RESET = 16'd256;

    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_REF   = 2'd1,
        CMD_FREE  = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_NO_FREE = 2'd1,
        ST_BAD_ID  = 2'd2
    } status_t;

    typedef struct packed {
        cmd_t              cmd;
        logic [SIZE_W-1:0] need_size;
        logic [ID_W-1:0]   buffer_id;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic [ID_W-1:0]    granted_id;
        logic               from_small_pool;
        logic               released;
        logic [COUNT_W-1:0] new_refcount;
    } rsp_t;

    function automatic logic [ID_SPACE-1:0] range_mask(input int lo, input int hi);
        logic [ID_SPACE-1:0] m;
        m = '0;
        for (int i = 0; i < ID_SPACE; i++)
        begin
            m[i] = (i >= lo) && (i < hi);
        end
        return m;
    endfunction

    localparam logic [ID_SPACE-1:0] SMALL_MASK = range_mask(0, SMALL_EFF);
    localparam logic [ID_SPACE-1:0] LARGE_MASK = range_mask(SMALL_EFF, TOTAL_EFF);

endpackage

FILE: hw/rtl/tpbuf_find_free.sv
module tpbuf_find_free (
    input  logic [tpbuf_pkg::ID_SPACE-1:0] free_mask,
    output logic                           found,
    output logic [tpbuf_pkg::ID_W-1:0]     first_id
);
    import tpbuf_pkg::*;

    always_comb
    begin
        found    = |free_mask;
        first_id = '0;
        for (int i = ID_SPACE - 1; i >= 0; i--)
        begin
            if (free_mask[i])
            begin
                first_id = ID_W'(i);
            end
        end
    end

endmodule

FILE: hw/rtl/tpbuf_state.sv
module tpbuf_state (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    input  tpbuf_pkg::req_t              req,
    input  logic [tpbuf_pkg::SIZE_W-1:0] small_limit,
    output tpbuf_pkg::rsp_t              rsp
);
    import tpbuf_pkg::*;

    logic [ID_SPACE-1:0] in_use_reg;
    logic [ID_SPACE-1:0] in_use_next;
    logic [COUNT_W-1:0]  count_reg [ID_SPACE];

    logic               small_found;
    logic               large_found;
    logic [ID_W-1:0]    small_id;
    logic [ID_W-1:0]    large_id;
    logic               in_range;
    logic               id_in_small_pool;
    logic [COUNT_W-1:0] cur_count;
    logic               count_we;
    logic [ID_W-1:0]    count_addr;
    logic [COUNT_W-1:0] count_next;

    tpbuf_find_free u_small_find (
        .free_mask (~in_use_reg & SMALL_MASK),
        .found     (small_found),
        .first_id  (small_id)
    );

    tpbuf_find_free u_large_find (
        .free_mask (~in_use_reg & LARGE_MASK),
        .found     (large_found),
        .first_id  (large_id)
    );

    assign in_range         = {1'b0, req.buffer_id} < (ID_W + 1)'(TOTAL_EFF);
    assign id_in_small_pool = {1'b0, req.buffer_id} < (ID_W + 1)'(SMALL_EFF);
    assign cur_count        = count_reg[req.buffer_id];

    always_comb
    begin
        in_use_next         = in_use_reg;
        count_we            = 1'b0;
        count_addr          = req.buffer_id;
        count_next          = cur_count;
        rsp.status          = ST_DONE;
        rsp.granted_id      = req.buffer_id;
        rsp.from_small_pool = 1'b0;
        rsp.released        = 1'b0;
        rsp.new_refcount    = '0;
        case (req.cmd)
            CMD_ALLOC:
            begin
                rsp.new_refcount = COUNT_ONE;
                count_next       = COUNT_ONE;
                if ((req.need_size <= small_limit) && small_found)
                begin
                    count_addr          = small_id;
                    count_we            = 1'b1;
                    rsp.granted_id      = small_id;
                    rsp.from_small_pool = 1'b1;
                end
                else if (large_found)
                begin
                    count_addr     = large_id;
                    count_we       = 1'b1;
                    rsp.granted_id = large_id;
                end
                else
                begin
                    rsp.status       = ST_NO_FREE;
                    rsp.granted_id   = '0;
                    rsp.new_refcount = '0;
                end
                if (count_we)
                begin
                    in_use_next[count_addr] = 1'b1;
                end
            end
            CMD_REF, CMD_FREE:
            begin
                if (!in_range)
                begin
                    rsp.status = ST_BAD_ID;
                end
                else
                begin
                    count_we            = 1'b1;
                    rsp.from_small_pool = id_in_small_pool;
                    if (req.cmd == CMD_REF)
                    begin
                        count_next = (cur_count == COUNT_MAX) ? cur_count
                                                              : cur_count + COUNT_ONE;
                    end
                    else if (cur_count > COUNT_ONE)
                    begin
                        count_next = cur_count - COUNT_ONE;
                    end
                    else
                    begin
                        count_next              = '0;
                        rsp.released            = 1'b1;
                        in_use_next[count_addr] = 1'b0;
                    end
                    rsp.new_refcount = count_next;
                end
            end
            default:
            begin
                rsp.status = ST_DONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use_reg <= '0;
            for (int i = 0; i < ID_SPACE; i++)
            begin
                count_reg[i] <= '0;
            end
        end
        else if (req_valid)
        begin
            in_use_reg <= in_use_next;
            if (count_we)
            begin
                count_reg[count_addr] <= count_next;
            end
        end
    end

endmodule

FILE: hw/rtl/two_pool_refcounted_buffer_allocator_top.sv
// An accepted request is registered in req_reg; its result is then registered in rsp_reg with result_valid.
// Throughput: one transaction per cycle; busy stays low, the buffer state updates
// in the same cycle as the result register, so the next request sees it.
// The receiver cannot stall: result_valid is high for exactly one cycle.
// Reset (rst_n, asynchronous): all buffers free, all counts zero, limit 256.
module two_pool_refcounted_buffer_allocator_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    cmd,
    input  logic [tpbuf_pkg::SIZE_W-1:0]  need_size,
    input  logic [tpbuf_pkg::ID_W-1:0]    buffer_id,
    input  logic                          cfg_wr_en,
    input  logic [tpbuf_pkg::SIZE_W-1:0]  cfg_wr_data,
    output logic                          result_valid,
    output logic [1:0]                    status,
    output logic [tpbuf_pkg::ID_W-1:0]    granted_id,
    output logic                          from_small_pool,
    output logic                          released,
    output logic [tpbuf_pkg::COUNT_W-1:0] new_refcount
);
    import tpbuf_pkg::*;

    logic              req_valid_reg;
    req_t              req_reg;
    logic              rsp_valid_reg;
    rsp_t              rsp_reg;
    rsp_t              rsp_next;
    logic [SIZE_W-1:0] limit_reg;

    assign busy = 1'b0;

    tpbuf_state u_state (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid_reg),
        .req         (req_reg),
        .small_limit (limit_reg),
        .rsp         (rsp_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= SMALL_LIMIT_RESET;
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
            end
            req_valid_reg <= start && !busy;
            rsp_valid_reg <= req_valid_reg;
        end
    end

    // hold payload; only the valid flags need reset
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            req_reg.cmd       <= cmd_t'(cmd);
            req_reg.need_size <= need_size;
            req_reg.buffer_id <= buffer_id;
        end
        if (req_valid_reg)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign result_valid    = rsp_valid_reg;
    assign status          = rsp_reg.status;
    assign granted_id      = rsp_reg.granted_id;
    assign from_small_pool = rsp_reg.from_small_pool;
    assign released        = rsp_reg.released;
    assign new_refcount    = rsp_reg.new_refcount;

endmodule

FILE: bench/two_pool_refcounted_buffer_allocator_top_test.sv
module two_pool_refcounted_buffer_allocator_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tpbuf_pkg::*;

    localparam int LATENCY       = 2;
    localparam int CYCLE_LIMIT   = 100000;
    localparam int SCRIPT_LEN    = 21;
    localparam int PHASE_ITEMS   = 110;
    localparam int SATURATE_REFS = 258;

    typedef struct packed {
        cmd_t              op;
        logic [SIZE_W-1:0] size;
        logic [ID_W-1:0]   id;
        logic              fixed;
        rsp_t              rsp;
    } step_t;

    localparam step_t SCRIPT [SCRIPT_LEN] = '{
        '{CMD_ALLOC, 16'h0000, 5'd0,  1'b1, '{ST_DONE, 5'd0,  1'b1, 1'b0, 8'd1}},
        '{CMD_ALLOC, 16'h0100, 5'd31, 1'b1, '{ST_DONE, 5'd1,  1'b1, 1'b0, 8'd1}},
        '{CMD_ALLOC, 16'h0101, 5'd0,  1'b1, '{ST_DONE, 5'd16, 1'b0, 1'b0, 8'd1}},
        '{CMD_ALLOC, 16'hFFFF, 5'd0,  1'b1, '{ST_DONE, 5'd17, 1'b0, 1'b0, 8'd1}},
        '{CMD_REF,   16'hFFFF, 5'd0,  1'b1, '{ST_DONE, 5'd0,  1'b1, 1'b0, 8'd2}},
        '{CMD_FREE,  16'h0000, 5'd0,  1'b1, '{ST_DONE, 5'd0,  1'b1, 1'b0, 8'd1}},
        '{CMD_FREE,  16'h0000, 5'd0,  1'b1, '{ST_DONE, 5'd0,  1'b1, 1'b1, 8'd0}},
        '{CMD_FREE,  16'hFFFF, 5'd0,  1'b1, '{ST_DONE, 5'd0,  1'b1, 1'b1, 8'd0}},
        '{CMD_REF,   16'h0000, 5'd5,  1'b1, '{ST_DONE, 5'd5,  1'b1, 1'b0, 8'd1}},
        '{CMD_REF,   16'h0000, 5'd5,  1'b1, '{ST_DONE, 5'd5,  1'b1, 1'b0, 8'd2}},
        '{CMD_FREE,  16'h0000, 5'd5,  1'b1, '{ST_DONE, 5'd5,  1'b1, 1'b0, 8'd1}},
        '{CMD_FREE,  16'h0000, 5'd5,  1'b1, '{ST_DONE, 5'd5,  1'b1, 1'b1, 8'd0}},
        '{CMD_REF,   16'h0000, 5'd31, 1'b1, '{ST_DONE, 5'd31, 1'b0, 1'b0, 8'd1}},
        '{CMD_FREE,  16'h0000, 5'd31, 1'b1, '{ST_DONE, 5'd31, 1'b0, 1'b1, 8'd0}},
        '{CMD_NOP,   16'hFFFF, 5'd31, 1'b1, '{ST_DONE, 5'd31, 1'b0, 1'b0, 8'd0}},
        '{CMD_NOP,   16'h0000, 5'd0,  1'b1, '{ST_DONE, 5'd0,  1'b0, 1'b0, 8'd0}},
        '{CMD_ALLOC, 16'h0001, 5'd0,  1'b0, '{ST_DONE, 5'd0,  1'b0, 1'b0, 8'd0}},
        '{CMD_ALLOC, 16'h5555, 5'd0,  1'b0, '{ST_DONE, 5'd0,  1'b0, 1'b0, 8'd0}},
        '{CMD_FREE,  16'h0000, 5'd16, 1'b0, '{ST_DONE, 5'd0,  1'b0, 1'b0, 8'd0}},
        '{CMD_ALLOC, 16'hAAAA, 5'd0,  1'b0, '{ST_DONE, 5'd0,  1'b0, 1'b0, 8'd0}},
        '{CMD_REF,   16'h0000, 5'd17, 1'b0, '{ST_DONE, 5'd0,  1'b0, 1'b0, 8'd0}}
    };

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [1:0]          cmd;
    logic [SIZE_W-1:0]   need_size;
    logic [ID_W-1:0]     buffer_id;
    logic                cfg_wr_en;
    logic [SIZE_W-1:0]   cfg_wr_data;
    logic                result_valid;
    logic [1:0]          status;
    logic [ID_W-1:0]     granted_id;
    logic                from_small_pool;
    logic                released;
    logic [COUNT_W-1:0]  new_refcount;

    logic [ID_SPACE-1:0] buf_in_use;
    logic [COUNT_W-1:0]  buf_refs [ID_SPACE];
    logic [SIZE_W-1:0]   small_limit;
    rsp_t                pending_rsp [$];

    int                  errors = 0;
    int                  requests_sent = 0;
    int                  results_seen = 0;
    int                  refusals = 0;
    int                  releases = 0;
    int                  saturations = 0;
    int                  idle_pct = 0;
    int unsigned         cycle_count = 0;

    two_pool_refcounted_buffer_allocator_top uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .cmd             (cmd),
        .need_size       (need_size),
        .buffer_id       (buffer_id),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .result_valid    (result_valid),
        .status          (status),
        .granted_id      (granted_id),
        .from_small_pool (from_small_pool),
        .released        (released),
        .new_refcount    (new_refcount)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int first_free(input int lo, input int hi);
        for (int i = lo; i < hi; i++)
        begin
            if (!buf_in_use[i])
                return i;
        end
        return -1;
    endfunction

    function automatic rsp_t serve_request(input cmd_t op, input logic [SIZE_W-1:0] size,
                                           input logic [ID_W-1:0] id);
        rsp_t r;
        int   pick;
        r = '0;
        r.status = ST_DONE;
        r.granted_id = id;
        pick = -1;
        case (op)
            CMD_ALLOC:
            begin
                if (size <= small_limit)
                    pick = first_free(0, SMALL_EFF);
                if (pick < 0)
                    pick = first_free(SMALL_EFF, TOTAL_EFF);
                r.granted_id = '0;
                if (pick < 0)
                begin
                    r.status = ST_NO_FREE;
                    refusals++;
                end
                else
                begin
                    buf_in_use[pick] = 1'b1;
                    buf_refs[pick] = COUNT_ONE;
                    r.granted_id = pick[ID_W-1:0];
                    r.from_small_pool = (pick < SMALL_EFF);
                    r.new_refcount = COUNT_ONE;
                end
            end
            CMD_NOP:
            begin
            end
            default:
            begin
                if (id >= TOTAL_EFF)
                    r.status = ST_BAD_ID;
                else
                begin
                    r.from_small_pool = (id < SMALL_EFF);
                    if (op == CMD_REF)
                    begin
                        if (buf_refs[id] != COUNT_MAX)
                            buf_refs[id] = buf_refs[id] + 1'b1;
                        else
                            saturations++;
                    end
                    else if (buf_refs[id] > COUNT_ONE)
                        buf_refs[id] = buf_refs[id] - 1'b1;
                    else
                    begin
                        buf_refs[id] = '0;
                        buf_in_use[id] = 1'b0;
                        r.released = 1'b1;
                        releases++;
                    end
                    r.new_refcount = buf_refs[id];
                end
            end
        endcase
        return r;
    endfunction

    function automatic logic [ID_W-1:0] held_buffer();
        int first;
        int idx;
        first = $urandom_range(0, TOTAL_EFF - 1);
        for (int k = 0; k < TOTAL_EFF; k++)
        begin
            idx = (first + k) % TOTAL_EFF;
            if (buf_in_use[idx])
                return idx[ID_W-1:0];
        end
        return ID_W'($urandom_range(0, ID_SPACE - 1));
    endfunction

    task automatic issue_request(input cmd_t op, input logic [SIZE_W-1:0] size,
                                 input logic [ID_W-1:0] id, input logic fixed,
                                 input rsp_t fixed_rsp);
        rsp_t want;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        cmd <= op;
        need_size <= size;
        buffer_id <= id;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        want = serve_request(op, size, id);
        pending_rsp.push_back(fixed ? fixed_rsp : want);
        requests_sent++;
    endtask

    task automatic drain();
        start <= 1'b0;
        do
            @(negedge clk);
        while (pending_rsp.size() != 0);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [COUNT_W-1:0] want,
                               input logic [COUNT_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        rsp_t want;
        if (result_valid === 1'b1)
        begin
            if (pending_rsp.size() == 0)
            begin
                $error("result with no transaction outstanding");
                errors++;
            end
            else
            begin
                want = pending_rsp.pop_front();
                check_field("status", COUNT_W'(want.status), COUNT_W'(status));
                check_field("granted_id", COUNT_W'(want.granted_id), COUNT_W'(granted_id));
                check_field("from_small_pool", COUNT_W'(want.from_small_pool),
                            COUNT_W'(from_small_pool));
                check_field("released", COUNT_W'(want.released), COUNT_W'(released));
                check_field("new_refcount", want.new_refcount, new_refcount);
                results_seen++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        rsp_t              none;
        logic [SIZE_W-1:0] size;
        logic [SIZE_W-1:0] limit_val;
        logic [ID_W-1:0]   hot;
        int                roll;
        none = '0;
        rst_n <= 1'b0;
        start <= 1'b0;
        cmd <= CMD_NOP;
        need_size <= '0;
        buffer_id <= '0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= '0;
        buf_in_use = '0;
        foreach (buf_refs[i])
            buf_refs[i] = '0;
        small_limit = SMALL_LIMIT_RESET;
        idle_pct = 19;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < SCRIPT_LEN; i++)
            issue_request(SCRIPT[i].op, SCRIPT[i].size, SCRIPT[i].id, SCRIPT[i].fixed,
                          SCRIPT[i].rsp);

        for (int phase = 0; phase < 3; phase++)
        begin
            drain();
            case (phase)
                0: limit_val = '0;
                1: limit_val = '1;
                default: limit_val = SIZE_W'($urandom);
            endcase
            cfg_wr_en <= 1'b1;
            cfg_wr_data <= limit_val;
            @(posedge clk);
            cfg_wr_en <= 1'b0;
            small_limit = limit_val;
            idle_pct = (phase == 0) ? 19 : (phase == 1) ? 78 : 0;

            // drive one buffer's count into saturation
            if (phase == 2)
            begin
                hot = ID_W'($urandom_range(0, TOTAL_EFF - 1));
                repeat (SATURATE_REFS)
                    issue_request(CMD_REF, SIZE_W'($urandom), hot, 1'b0, none);
            end

            repeat (PHASE_ITEMS)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 25)
                begin
                    case ($urandom_range(0, 4))
                        0: size = '0;
                        1: size = small_limit;
                        2: size = small_limit + 1'b1;
                        3: size = '1;
                        default: size = SIZE_W'($urandom);
                    endcase
                    issue_request(CMD_ALLOC, size, ID_W'($urandom), 1'b0, none);
                end
                else if (roll < 45)
                    issue_request(CMD_REF, SIZE_W'($urandom), held_buffer(), 1'b0, none);
                else if (roll < 90)
                    issue_request(CMD_FREE, SIZE_W'($urandom), held_buffer(), 1'b0, none);
                else
                    issue_request(cmd_t'($urandom_range(0, 3)), SIZE_W'($urandom),
                                  ID_W'($urandom), 1'b0, none);
            end
        end

        drain();
        $display("%0d transactions, %0d results checked over limits 256, 0, 65535 and %0d",
                 requests_sent, results_seen, small_limit);
        $display("%0d allocations refused, %0d releases, %0d increments held at saturation",
                 refusals, releases, saturations);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
